/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the neighbor count design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CHK_IMPL(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CHK_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mnc_pkg.sv */
// ----------------------------------------------------------------------------
// mnc_pkg
// Shared types and constants of the mine neighbor count block.
// ----------------------------------------------------------------------------
package mnc_pkg;

	localparam int CFG_W        = 6;
	localparam int MAX_SIZE_DEF = 32;
	localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

	localparam int TDATA_W = 8;
	localparam int COUNT_W = 4;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QCW    = 3;

	// One reported cell: the three rows of its 3x3 window, bit 1 is the cell column.
	typedef struct packed {
		logic [2:0] above;
		logic [2:0] mid;
		logic [2:0] below;
		logic       row_end;
		logic       grid_end;
	} job_t;

	// Up to two cells enter the queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		job_t       j0;
		job_t       j1;
	} push_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic [QCW-1:0] free;
		logic           not_empty;
	} qstat_t;

endpackage

/* rtl/mnc_front.sv */
// ----------------------------------------------------------------------------
// mnc_front
// Takes cells, keeps three row buffers and turns each cell into window jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnc_front #(
	parameter int MAX_SIZE = mnc_pkg::MAX_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [mnc_pkg::CFG_W-1:0] grid_size,
	input  logic                     cfg_we,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_bit,
	input  mnc_pkg::qstat_t          qstat,
	output mnc_pkg::push_t           push
);
	import mnc_pkg::*;

	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam logic [CFG_W:0] MAX_CMP = MAX_SIZE[CFG_W:0];

	logic [MAX_SIZE-1:0] older_q, middle_q, cur_q, cur_upd;
	logic [IW-1:0]       row_q, col_q, fcol_q, n_m1, col_m1;
	logic                flush_q;
	logic                accept, last_col, last_row, e1, e2, flush_go;
	job_t                job_a, job_b, job_f;

	function automatic logic [2:0] win3(input logic [MAX_SIZE-1:0] row,
		input logic [IW-1:0] idx);
		logic [MAX_SIZE+1:0] pad;
		pad = {1'b0, row, 1'b0};
		return pad[idx +: 3];
	endfunction

	always_comb begin
		if (grid_size == '0) begin
			n_m1 = '0;
		end else if ({1'b0, grid_size} > MAX_CMP) begin
			n_m1 = IW'(MAX_SIZE - 1);
		end else begin
			n_m1 = IW'(grid_size - 1'b1);
		end
	end

	assign in_ready = !flush_q && (qstat.free >= QCW'(2));
	assign accept   = in_valid && in_ready;
	assign flush_go = flush_q && (qstat.free != '0);
	assign last_col = (col_q == n_m1);
	assign last_row = (row_q == n_m1);
	assign e1       = (row_q != '0) && (col_q != '0);
	assign e2       = (row_q != '0) && last_col;
	assign col_m1   = IW'(col_q - 1'b1);
	assign cur_upd  = cur_q | (MAX_SIZE'(in_bit) << col_q);

	always_comb begin
		job_a.above    = win3(older_q, col_m1);
		job_a.mid      = win3(middle_q, col_m1);
		job_a.below    = win3(cur_upd, col_m1);
		job_a.row_end  = 1'b0;
		job_a.grid_end = 1'b0;
		job_b.above    = win3(older_q, col_q);
		job_b.mid      = win3(middle_q, col_q);
		job_b.below    = win3(cur_upd, col_q);
		job_b.row_end  = 1'b1;
		job_b.grid_end = 1'b0;
		job_f.above    = win3(middle_q, fcol_q);
		job_f.mid      = win3(cur_q, fcol_q);
		job_f.below    = 3'b000;
		job_f.row_end  = (fcol_q == n_m1);
		job_f.grid_end = (fcol_q == n_m1);
	end

	always_comb begin
		push.cnt = 2'd0;
		push.j0  = job_b;
		push.j1  = job_b;
		if (flush_go) begin
			push.cnt = 2'd1;
			push.j0  = job_f;
		end else if (accept) begin
			push.cnt = {1'b0, e1} + {1'b0, e2};
			push.j0  = e1 ? job_a : job_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			middle_q <= '0;
			cur_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			fcol_q   <= '0;
			flush_q  <= 1'b0;
		end else if (cfg_we) begin
			older_q  <= '0;
			middle_q <= '0;
			cur_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			fcol_q   <= '0;
			flush_q  <= 1'b0;
		end else if (flush_go) begin
			if (fcol_q == n_m1) begin
				older_q  <= '0;
				middle_q <= '0;
				cur_q    <= '0;
				row_q    <= '0;
				col_q    <= '0;
				fcol_q   <= '0;
				flush_q  <= 1'b0;
			end else begin
				fcol_q <= IW'(fcol_q + 1'b1);
			end
		end else if (accept) begin
			if (last_col) begin
				if (last_row) begin
					cur_q   <= cur_upd;
					fcol_q  <= '0;
					flush_q <= 1'b1;
				end else begin
					older_q  <= middle_q;
					middle_q <= cur_upd;
					cur_q    <= '0;
					row_q    <= IW'(row_q + 1'b1);
					col_q    <= '0;
				end
			end else begin
				cur_q <= cur_upd;
				col_q <= IW'(col_q + 1'b1);
			end
		end
	end

	`CHK_IMPL(a_flush_blocks_input, clk, arst_n, flush_q, !in_ready, "input taken during flush")
	`CHK_NEXT(a_last_cell_flushes, clk, arst_n, accept && last_col && last_row && !cfg_we, flush_q, "final cell did not start flush")
	`CHK_IMPL(a_flush_end_clears, clk, arst_n, $fell(flush_q), (row_q == '0) && (col_q == '0), "indices not cleared after flush")

endmodule

/* rtl/mnc_queue.sv */
// ----------------------------------------------------------------------------
// mnc_queue
// Short job queue between front and back; up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  mnc_pkg::push_t  push,
	input  logic            pop,
	output mnc_pkg::job_t   pop_job,
	output mnc_pkg::qstat_t qstat
);
	import mnc_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	assign qstat.free      = QCW'(QDEPTH) - cnt_q;
	assign qstat.not_empty = (cnt_q != '0);
	assign pop_job         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.j0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[QAW'(wr_q + 1'b1)] <= push.j1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= QAW'(wr_q + push.cnt);
			rd_q  <= QAW'(rd_q + pop);
			cnt_q <= QCW'(cnt_q + push.cnt - pop);
		end
	end

	`CHK_IMPL(a_no_overflow, clk, arst_n, 1'b1, QCW'(push.cnt) <= qstat.free, "queue overflow")
	`CHK_IMPL(a_no_underflow, clk, arst_n, pop, qstat.not_empty, "pop from empty queue")
	`CHK_IMPL(a_count_bound, clk, arst_n, 1'b1, cnt_q <= QCW'(QDEPTH), "queue count out of range")

endmodule

/* rtl/mnc_back.sv */
// ----------------------------------------------------------------------------
// mnc_back
// Counts neighbor mines of each queued window and holds the output beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mnc_pkg::job_t              job,
	input  logic                       job_avail,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_mine,
	output logic [mnc_pkg::COUNT_W-1:0] out_count,
	output logic                       out_row_end,
	output logic                       out_grid_end
);
	import mnc_pkg::*;

	logic               valid_q, mine_q, row_end_q, grid_end_q;
	logic [COUNT_W-1:0] count_q, count_c;

	assign pop = job_avail && (!valid_q || out_ready);

	always_comb begin
		if (job.mid[1]) begin
			count_c = '0;
		end else begin
			count_c = COUNT_W'(job.above[0]) + COUNT_W'(job.above[1])
				+ COUNT_W'(job.above[2]) + COUNT_W'(job.mid[0])
				+ COUNT_W'(job.mid[2]) + COUNT_W'(job.below[0])
				+ COUNT_W'(job.below[1]) + COUNT_W'(job.below[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mine_q     <= job.mid[1];
			count_q    <= count_c;
			row_end_q  <= job.row_end;
			grid_end_q <= job.grid_end;
		end
	end

	assign out_valid    = valid_q;
	assign out_mine     = mine_q;
	assign out_count    = count_q;
	assign out_row_end  = row_end_q;
	assign out_grid_end = grid_end_q;

	`CHK_IMPL(a_mine_zero_count, clk, arst_n, valid_q && mine_q, count_q == '0, "mine cell with nonzero count")
	`CHK_IMPL(a_grid_end_row_end, clk, arst_n, valid_q && grid_end_q, row_end_q, "grid end not at row end")
	`CHK_NEXT(a_hold, clk, arst_n, valid_q && !out_ready, valid_q && $stable(count_q), "stalled beat changed")

endmodule

/* rtl/mine_neighbor_count_top.sv */
// ----------------------------------------------------------------------------
// mine_neighbor_count_top
// Streaming minesweeper neighbor count over a square grid.
// ----------------------------------------------------------------------------
// Cells enter on the slave stream in row-major order, one beat per cell, with
// the mine flag in s_tdata bit 0. Each master beat reports one cell: its mine
// flag and neighbor count in m_tdata, tlast on the last column of a row and
// tuser on the last cell of the grid. Reports trail the input by one row and
// one column; the final cell of a grid flushes the whole last row.
// A cell is taken every cycle while s_tready is high; a beat that closes a
// row after the first queues two reports. Reports pass through the job queue
// and the output register on their way to the master side. The final cell
// starts a flush, one report per grid column, during which s_tready is low.
// A four-entry job queue separates the row buffers from the counting stage,
// so a stalled receiver stops input only once the queue lacks room for two.
// Reset clears all rows and positions and sets the grid size to 32. Writing
// cfg_wdata with cfg_we starts a fresh grid; sizes of 0 act as 1 and sizes
// above MAX_SIZE act as MAX_SIZE.
// ----------------------------------------------------------------------------
module mine_neighbor_count_top #(
	parameter int MAX_SIZE = mnc_pkg::MAX_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mnc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mnc_pkg::TDATA_W-1:0] s_tdata,  // [0] is_mine, [7:1] zero
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mnc_pkg::TDATA_W-1:0] m_tdata,  // [0] cell_is_mine, [4:1] mine_count
	output logic                        m_tlast,
	output logic [0:0]                  m_tuser   // [0] grid_end
);
	import mnc_pkg::*;

	logic [CFG_W-1:0]   grid_size_q;
	push_t              push;
	qstat_t             qstat;
	job_t               pop_job;
	logic               pop, out_mine, out_grid_end;
	logic [COUNT_W-1:0] out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_RESET;
		end else if (cfg_we) begin
			grid_size_q <= cfg_wdata;
		end
	end

	mnc_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_size (grid_size_q),
		.cfg_we    (cfg_we),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_bit    (s_tdata[0]),
		.qstat     (qstat),
		.push      (push)
	);

	mnc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.pop_job (pop_job),
		.qstat   (qstat)
	);

	mnc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (pop_job),
		.job_avail    (qstat.not_empty),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_mine     (out_mine),
		.out_count    (out_count),
		.out_row_end  (m_tlast),
		.out_grid_end (out_grid_end)
	);

	assign m_tdata    = {(TDATA_W - COUNT_W - 1)'(0), out_count, out_mine};
	assign m_tuser[0] = out_grid_end;

endmodule

/* bench/mine_neighbor_count_top_tb.sv */
// ----------------------------------------------------------------------------
// mine_neighbor_count_top_tb
// Self-checking bench for the streaming minesweeper neighbor count block.
// ----------------------------------------------------------------------------
// Cells are streamed in with random gaps while the result side stalls at
// random. A scoreboard object keeps its own copy of the three row buffers
// and the grid position, predicts every reported cell on each accepted input
// beat and checks the result beats in order. A short directed part covers the
// size extremes, full and empty neighborhoods and a size change in the middle
// of a grid; random grids of many sizes and mine densities follow, with one
// long receiver stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module mine_neighbor_count_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mnc_pkg::*;

	localparam int SIDE_MAX      = MAX_SIZE_DEF;
	localparam int SETTLE_CYCLES = 2 * SIDE_MAX;
	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_CELLS  = 470;
	localparam int HOLD_CYCLES   = 100;

	typedef struct {
		bit               mine;
		bit [COUNT_W-1:0] count;
		bit               row_end;
		bit               grid_end;
	} cell_report_t;

	class neighbor_counter;
		logic [CFG_W-1:0]  side_reg;
		bit [SIDE_MAX-1:0] row_up2;
		bit [SIDE_MAX-1:0] row_up1;
		bit [SIDE_MAX-1:0] row_live;
		int                at_row;
		int                at_col;
		cell_report_t      pending_reports[$];
		int                errors;
		int                cells_taken;
		int                reports_checked;
		int                grids_done;
		int                cfg_writes;

		function new();
			side_reg = GRID_RESET;
			wipe();
		endfunction

		function void wipe();
			row_up2 = '0;
			row_up1 = '0;
			row_live = '0;
			at_row = 0;
			at_col = 0;
		endfunction

		function int eff_side();
			int n;
			n = int'(side_reg);
			if (n < 1) n = 1;
			if (n > SIDE_MAX) n = SIDE_MAX;
			return n;
		endfunction

		function void set_side(logic [CFG_W-1:0] value);
			side_reg = value;
			cfg_writes++;
			wipe();
		endfunction

		function void add_report(bit [SIDE_MAX-1:0] up, bit [SIDE_MAX-1:0] mid,
				bit [SIDE_MAX-1:0] down, int row, int col, int n);
			cell_report_t rep;
			int k;
			rep.mine = mid[col];
			rep.count = '0;
			if (!rep.mine) begin
				for (k = col - 1; k <= col + 1; k++) begin
					if (k >= 0 && k < SIDE_MAX) begin
						rep.count += COUNT_W'(up[k]) + COUNT_W'(down[k]);
						if (k != col) rep.count += COUNT_W'(mid[k]);
					end
				end
			end
			rep.row_end = (col == n - 1);
			rep.grid_end = (col == n - 1) && (row == n - 1);
			pending_reports.push_back(rep);
		endfunction

		function void note_cell(bit mine);
			int n;
			int r;
			int c;
			int j;
			n = eff_side();
			r = at_row;
			c = at_col;
			cells_taken++;
			if (r >= n || c >= n) begin
				wipe();
				r = 0;
				c = 0;
			end
			row_live[c] = mine;
			if (r >= 1 && c >= 1) add_report(row_up2, row_up1, row_live, r - 1, c - 1, n);
			if (c == n - 1) begin
				if (r >= 1) add_report(row_up2, row_up1, row_live, r - 1, c, n);
				if (r == n - 1) begin
					for (j = 0; j < n; j++) add_report(row_up1, row_live, '0, r, j, n);
					grids_done++;
					wipe();
				end else begin
					row_up2 = row_up1;
					row_up1 = row_live;
					row_live = '0;
					at_row = r + 1;
					at_col = 0;
				end
			end else begin
				at_row = r;
				at_col = c + 1;
			end
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH on report %0d: %s", reports_checked, what);
		endtask

		task check_report(bit mine, bit [COUNT_W-1:0] count, bit row_end, bit grid_end);
			cell_report_t want;
			reports_checked++;
			if (pending_reports.size() == 0) begin
				report($sformatf("unexpected beat mine=%0d count=%0d row_end=%0d grid_end=%0d",
					mine, count, row_end, grid_end));
				return;
			end
			want = pending_reports.pop_front();
			if (mine != want.mine)
				report($sformatf("cell_is_mine %0d, expected %0d", mine, want.mine));
			if (count != want.count)
				report($sformatf("mine_count %0d, expected %0d", count, want.count));
			if (row_end != want.row_end)
				report($sformatf("row_end %0d, expected %0d", row_end, want.row_end));
			if (grid_end != want.grid_end)
				report($sformatf("grid_end %0d, expected %0d", grid_end, want.grid_end));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic [0:0]         m_tuser;

	bit burst_mode = 1'b0;
	bit hold_armed = 1'b0;
	neighbor_counter counter = new();

	mine_neighbor_count_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	task automatic send_cell(input bit mine);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_W-1){1'b0}}, mine};
		do @(posedge clk); while (!s_tready);
		counter.note_cell(mine);
	endtask

	task automatic send_pattern(input int len, input bit [31:0] cells);
		int i;
		for (i = 0; i < len; i++) send_cell(cells[i]);
	endtask

	task automatic send_random(input int len, input int density);
		int i;
		for (i = 0; i < len; i++) send_cell($urandom_range(0, 99) < density);
	endtask

	// The block is idle only once every report has come out and any flush is over.
	task automatic write_side(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (counter.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		counter.set_side(value);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_armed) begin
				hold_armed = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = burst_mode ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			counter.check_report(m_tdata[0], m_tdata[COUNT_W:1], m_tlast, m_tuser[0]);
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles, %0d reports outstanding.",
			IDLE_LIMIT, counter.pending_reports.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int kind;
		int side;
		int n;
		int len;
		int density;
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Part of a grid at the reset size, then a size change cuts it off.
		send_pattern(3, 32'b101);
		write_side(6'd0);
		send_pattern(2, 32'b01);
		write_side(6'd2);
		send_pattern(4, 32'hF);
		// An empty center cell surrounded by eight mines.
		write_side(6'd3);
		send_pattern(9, 32'h1EF);
		write_side(6'd1);
		send_pattern(1, 32'b1);
		write_side(6'd63);
		send_pattern(4, 32'b0);

		// Full-rate grids while the receiver holds off for a long stretch.
		write_side(6'd6);
		burst_mode = 1'b1;
		hold_armed = 1'b1;
		send_random(72, 40);
		sent = 72;

		while (sent < RANDOM_CELLS) begin
			kind = $urandom_range(0, 9);
			density = $urandom_range(0, 100);
			burst_mode = ($urandom_range(0, 3) == 0);
			if (kind == 0) side = $urandom_range(0, 1);
			else if (kind == 6) side = $urandom_range(9, 16);
			else if (kind == 7) side = $urandom_range(0, 1) ? SIDE_MAX : $urandom_range(SIDE_MAX + 1, 63);
			else side = $urandom_range(2, 8);
			write_side(CFG_W'(side));
			n = counter.eff_side();
			if (kind == 6 || kind == 7) len = n * $urandom_range(1, 2) + $urandom_range(0, n - 1);
			else if (kind >= 8) len = n * n + $urandom_range(1, n * n - 1);
			else len = n * n * $urandom_range(1, (kind == 0) ? 6 : 2);
			send_random(len, density);
			sent += len;
		end

		s_tvalid <= 1'b0;
		while (counter.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d cells, %0d complete grids and %0d reported cells",
			counter.cells_taken, counter.grids_done, counter.reports_checked);
		$display("across %0d grid size writes, with %0d mismatches.",
			counter.cfg_writes, counter.errors);
		if (counter.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/mnc_pkg.sv
rtl/mnc_front.sv
rtl/mnc_queue.sv
rtl/mnc_back.sv
rtl/mine_neighbor_count_top.sv
bench/mine_neighbor_count_top_tb.sv
